### design/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared constants and types for the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int          COLOR_W     = 24;
    localparam logic [23:0] COLOR_RESET = 24'h00FF00;

    // item opcodes carried on the action field
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_STEP = 3'b100
    } dda_state_t;

endpackage

### design/dda_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer_top
// Fixed-point DDA line rasterizer with serial divider and serial accumulators.
// ----------------------------------------------------------------------------
// Load item: accepted, then, for a nonzero line length, bit-serial division and
//   increment load run before the next item is taken.
// Step item: pixel is in the output register the cycle after acceptance; the
//   bit-serial accumulator add then runs before the next item is taken.
// Reset: no active line, color back to 0x00FF00; the accumulators are not reset.
module dda_line_rasterizer_top #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic [COORD_BITS-1:0]       x_start,
    input  logic [COORD_BITS-1:0]       y_start,
    input  logic [COORD_BITS-1:0]       x_end,
    input  logic [COORD_BITS-1:0]       y_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COORD_BITS-1:0]       pixel_x,
    output logic [COORD_BITS-1:0]       pixel_y,
    output logic [dda_pkg::COLOR_W-1:0] pixel_value,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dda_pkg::COLOR_W-1:0] cfg_data
);

    import dda_pkg::*;

    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 2;
    localparam int INC_W  = FRAC_BITS + 2;
    localparam int DVD_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_W = COORD_BITS + 1;
    localparam int CNT_W  = $clog2(ACC_W);

    dda_state_t state_reg, state_next;

    logic [STEP_W-1:0]     steps_left_reg, steps_left_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COLOR_W-1:0]    color_reg;
    logic                  x_neg_reg, y_neg_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg, pixel_y_reg;
    logic [COLOR_W-1:0]    pixel_value_reg;
    logic                  last_reg;

    logic                  in_fire;
    logic                  load_fire;
    logic                  step_fire;
    logic                  pix_fire;
    logic [COORD_BITS-1:0] adx, ady, n_len;
    logic [DVD_W-1:0]      x_dvd, y_dvd;
    logic                  div_start;
    logic                  x_done, y_done;
    logic [DVD_W-1:0]      x_quo, y_quo;
    logic [INC_W-1:0]      x_mag, y_mag, x_inc, y_inc;
    logic [ACC_W-1:0]      x_acc_init, y_acc_init;
    logic [ACC_W-1:0]      x_acc, y_acc;
    logic                  add_shift;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign load_fire = in_fire && (action == ACT_LOAD);
    assign step_fire = in_fire && (action == ACT_STEP);
    assign pix_fire  = step_fire && (steps_left_reg != '0);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        adx   = (x_end >= x_start) ? (x_end - x_start) : (x_start - x_end);
        ady   = (y_end >= y_start) ? (y_end - y_start) : (y_start - y_end);
        n_len = (adx > ady) ? adx : ady;
        // span scaled to fixed point plus half the divisor, for round-half-up
        x_dvd = {1'b0, adx, {FRAC_BITS{1'b0}}} + DVD_W'(n_len >> 1);
        y_dvd = {1'b0, ady, {FRAC_BITS{1'b0}}} + DVD_W'(n_len >> 1);
        // start point plus one half
        x_acc_init = {2'b00, x_start, 1'b1, {(FRAC_BITS-1){1'b0}}};
        y_acc_init = {2'b00, y_start, 1'b1, {(FRAC_BITS-1){1'b0}}};
    end

    assign div_start = load_fire && (n_len != '0);

    dda_div #(
        .DVD_W (DVD_W),
        .DIV_W (COORD_BITS)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (x_dvd),
        .divisor  (n_len),
        .done     (x_done),
        .quotient (x_quo)
    );

    dda_div #(
        .DVD_W (DVD_W),
        .DIV_W (COORD_BITS)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (y_dvd),
        .divisor  (n_len),
        .done     (y_done),
        .quotient (y_quo)
    );

    // quotient never exceeds one whole unit, so FRAC_BITS+1 bits hold it
    always_comb
    begin
        x_mag = {1'b0, x_quo[FRAC_BITS:0]};
        y_mag = {1'b0, y_quo[FRAC_BITS:0]};
        x_inc = x_neg_reg ? (~x_mag + 1'b1) : x_mag;
        y_inc = y_neg_reg ? (~y_mag + 1'b1) : y_mag;
    end

    assign add_shift = (state_reg == S_STEP);

    dda_acc #(
        .ACC_W (ACC_W),
        .INC_W (INC_W)
    ) u_acc_x (
        .clk       (clk),
        .acc_load  (load_fire),
        .acc_val   (x_acc_init),
        .inc_load  (x_done),
        .inc_val   (x_inc),
        .add_start (pix_fire),
        .add_shift (add_shift),
        .acc       (x_acc)
    );

    dda_acc #(
        .ACC_W (ACC_W),
        .INC_W (INC_W)
    ) u_acc_y (
        .clk       (clk),
        .acc_load  (load_fire),
        .acc_val   (y_acc_init),
        .inc_load  (y_done),
        .inc_val   (y_inc),
        .add_start (pix_fire),
        .add_shift (add_shift),
        .acc       (y_acc)
    );

    always_comb
    begin
        state_next      = state_reg;
        steps_left_next = steps_left_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (load_fire)
                begin
                    steps_left_next = STEP_W'(n_len);
                    if (n_len != '0)
                    begin
                        state_next = S_DIV;
                    end
                end
                else if (pix_fire)
                begin
                    steps_left_next = steps_left_reg - 1'b1;
                    out_valid_next  = 1'b1;
                    cnt_next        = '0;
                    state_next      = S_STEP;
                end
            end
            S_DIV:
            begin
                if (x_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_STEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ACC_W - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            steps_left_reg <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            color_reg      <= COLOR_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            steps_left_reg <= steps_left_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                color_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            x_neg_reg <= (x_end < x_start);
            y_neg_reg <= (y_end < y_start);
        end
        if (pix_fire)
        begin
            pixel_x_reg     <= x_acc[FRAC_BITS +: COORD_BITS];
            pixel_y_reg     <= y_acc[FRAC_BITS +: COORD_BITS];
            pixel_value_reg <= color_reg;
            last_reg        <= (steps_left_reg == STEP_W'(1));
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_value = pixel_value_reg;
    assign last        = last_reg;

endmodule

### design/dda_div.sv
// ----------------------------------------------------------------------------
// dda_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dda_div #(
    parameter int DVD_W = 27,
    parameter int DIV_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DIV_W:0] rem_sh;
    logic [DIV_W:0] diff;
    logic           q_bit;

    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        diff   = rem_sh - {1'b0, dsr_reg};
        q_bit  = ~diff[DIV_W];
    end

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            dvd_next = {dvd_reg[DVD_W-2:0], q_bit};
            rem_next = q_bit ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

### design/dda_acc.sv
// ----------------------------------------------------------------------------
// dda_acc
// One axis accumulator, updated by a bit-serial adder, LSB first.
// ----------------------------------------------------------------------------
module dda_acc #(
    parameter int ACC_W = 28,
    parameter int INC_W = 18
) (
    input  logic             clk,
    input  logic             acc_load,
    input  logic [ACC_W-1:0] acc_val,
    input  logic             inc_load,
    input  logic [INC_W-1:0] inc_val,
    input  logic             add_start,
    input  logic             add_shift,
    output logic [ACC_W-1:0] acc
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [INC_W-1:0] inc_reg, inc_next;
    logic [INC_W-1:0] inc_sh_reg, inc_sh_next;
    logic             carry_reg, carry_next;
    logic             sum_bit;

    always_comb
    begin
        sum_bit     = acc_reg[0] ^ inc_sh_reg[0] ^ carry_reg;
        acc_next    = acc_reg;
        inc_next    = inc_reg;
        inc_sh_next = inc_sh_reg;
        carry_next  = carry_reg;
        if (acc_load)
        begin
            acc_next = acc_val;
        end
        else if (add_shift)
        begin
            // rotate the sum in at the top; the sign of the increment repeats
            acc_next    = {sum_bit, acc_reg[ACC_W-1:1]};
            inc_sh_next = {inc_sh_reg[INC_W-1], inc_sh_reg[INC_W-1:1]};
            carry_next  = (acc_reg[0] & inc_sh_reg[0]) | (acc_reg[0] & carry_reg)
                        | (inc_sh_reg[0] & carry_reg);
        end
        if (inc_load)
        begin
            inc_next = inc_val;
        end
        if (add_start)
        begin
            inc_sh_next = inc_reg;
            carry_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        inc_reg    <= inc_next;
        inc_sh_reg <= inc_sh_next;
        carry_reg  <= carry_next;
    end

    assign acc = acc_reg;

endmodule

### design/dda_chk.sv
// ----------------------------------------------------------------------------
// dda_chk
// Port-level checks for the DDA line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module dda_chk #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        action,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [COORD_BITS-1:0]       pixel_x,
    input logic [COORD_BITS-1:0]       pixel_y,
    input logic [dda_pkg::COLOR_W-1:0] pixel_value,
    input logic                        last
);

    import dda_pkg::*;

    // a new pixel only follows an accepted step item
    a_pix_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && action == ACT_STEP))
        else $error("pixel appeared without a step item");

    // a load never produces a pixel
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == ACT_LOAD) |=> !$rose(out_valid))
        else $error("load item produced a pixel");

    // the serial add keeps the input closed right after a pixel is issued
    a_busy_after_pix: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("input open during accumulator update");

    // a stalled pixel holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pixel_x) && $stable(pixel_y)
            && $stable(pixel_value) && $stable(last)))
        else $error("stalled pixel changed");

endmodule

bind dda_line_rasterizer_top dda_chk #(
    .COORD_BITS (COORD_BITS)
) u_dda_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_value (pixel_value),
    .last        (last)
);

### tb/dda_line_rasterizer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dda_line_rasterizer_top_tb
// Drives line loads and pixel steps into the DDA rasterizer and checks every
// pixel against a fixed-point line walker kept inside the bench. A short table
// of hand-picked lines comes first, then random line sequences under three
// colors: two phases with random stalls on both sides, then one without stalls.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_top_tb;
    import dda_pkg::*;

    localparam int COORD_W = dda_pkg::COORD_BITS_DEF;
    localparam int FRAC_W  = dda_pkg::FRAC_BITS_DEF;
    localparam int ACC_W   = COORD_W + FRAC_W + 2;
    localparam int INC_W   = FRAC_W + 2;

    localparam logic [COORD_W-1:0] C_MAX    = '1;
    localparam logic [ACC_W-1:0]   ACC_HALF = ACC_W'(1) << (FRAC_W - 1);

    // longest internal pass (serial accumulator add) plus some slack
    localparam int REST_CYCLES = COORD_W + FRAC_W + 10;
    localparam int STALL_LIMIT = 2000;
    localparam int DIR_N       = 25;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
    } line_cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] ys;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ye;
        logic               typed;
        logic [COORD_W-1:0] wx;
        logic [COORD_W-1:0] wy;
        logic               wlast;
    } dir_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic               action    = ACT_LOAD;
    logic [COORD_W-1:0] x_start   = '0;
    logic [COORD_W-1:0] y_start   = '0;
    logic [COORD_W-1:0] x_end     = '0;
    logic [COORD_W-1:0] y_end     = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_value;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COLOR_W-1:0] cfg_data  = '0;

    // line walker state
    logic [ACC_W-1:0]   acc_x         = '0;
    logic [ACC_W-1:0]   acc_y         = '0;
    logic [INC_W-1:0]   inc_x         = '0;
    logic [INC_W-1:0]   inc_y         = '0;
    logic [COORD_W:0]   pix_remaining = '0;
    logic [COLOR_W-1:0] color_reg     = COLOR_RESET;

    pixel_t pix_due[$];

    int  errors         = 0;
    int  useful_items   = 0;
    int  items_sent     = 0;
    int  lines_loaded   = 0;
    int  pixels_checked = 0;
    int  tx_gap_pct     = 20;
    int  rx_gap_pct     = 20;
    int  rx_hold        = 0;
    int  rx_tick        = 0;
    int  quiet          = 0;
    bit  calm           = 1'b0;

    dir_row_t dir_rows [DIR_N] = '{
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_LOAD, 10'd0,   10'd0,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_LOAD, 10'd0,   10'd0,   10'd3,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b1, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b1, 10'd1,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b1, 10'd2,    10'd0,    1'b1},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_LOAD, C_MAX,   C_MAX,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b1, 10'd1023, 10'd1023, 1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b1, 10'd1022, 10'd1022, 1'b0},
        '{ACT_LOAD, 10'd0,   C_MAX,   C_MAX,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b1, 10'd0,    10'd1023, 1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_LOAD, 10'd5,   10'd5,   10'd6,   10'd7,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_LOAD, C_MAX,   10'd0,   C_MAX,   10'd1,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b1, 10'd1023, 10'd0,    1'b1},
        '{ACT_LOAD, 10'd512, 10'd341, 10'd0,   10'd682, 1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_LOAD, 10'd1,   10'd2,   10'd4,   10'd3,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0},
        '{ACT_STEP, 10'd0,   10'd0,   10'd0,   10'd0,   1'b0, 10'd0,    10'd0,    1'b0}
    };

    dda_line_rasterizer_top #(
        .COORD_BITS(COORD_W),
        .FRAC_BITS (FRAC_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_value(pixel_value),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // rounded per-step increment (b - a) / n, two's complement at INC_W bits
    function automatic logic [INC_W-1:0] slope(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b,
                                               input logic [COORD_W:0]   n);
        logic [31:0]      span_len;
        logic [31:0]      mag;
        logic [INC_W-1:0] res;
        span_len = (b >= a) ? 32'(b) - 32'(a) : 32'(a) - 32'(b);
        mag      = ((span_len << FRAC_W) + (32'(n) >> 1)) / 32'(n);
        res      = mag[INC_W-1:0];
        if (b < a)
            res = -res;
        return res;
    endfunction

    // apply one item to the line walker; returns 1 when a pixel comes out
    function automatic bit raster_next(input line_cmd_t cmd, output pixel_t pix);
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [COORD_W:0]   n;
        logic [ACC_W-1:0]   base_x;
        logic [ACC_W-1:0]   base_y;
        pix = '0;
        if (cmd.action == ACT_LOAD)
        begin
            dx = (cmd.x_end >= cmd.x_start) ? cmd.x_end - cmd.x_start
                                            : cmd.x_start - cmd.x_end;
            dy = (cmd.y_end >= cmd.y_start) ? cmd.y_end - cmd.y_start
                                            : cmd.y_start - cmd.y_end;
            n  = (dx > dy) ? {1'b0, dx} : {1'b0, dy};
            if (n != 0)
            begin
                inc_x = slope(cmd.x_start, cmd.x_end, n);
                inc_y = slope(cmd.y_start, cmd.y_end, n);
            end
            else
            begin
                inc_x = '0;
                inc_y = '0;
            end
            base_x = ACC_W'(cmd.x_start);
            base_y = ACC_W'(cmd.y_start);
            acc_x  = (base_x << FRAC_W) + ACC_HALF;
            acc_y  = (base_y << FRAC_W) + ACC_HALF;
            pix_remaining = n;
            return 1'b0;
        end
        if (pix_remaining == 0)
            return 1'b0;
        pix.px    = acc_x[FRAC_W +: COORD_W];
        pix.py    = acc_y[FRAC_W +: COORD_W];
        pix.color = color_reg;
        pix.last  = (pix_remaining == 1);
        acc_x = acc_x + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
        acc_y = acc_y + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
        pix_remaining = pix_remaining - 1'b1;
        return 1'b1;
    endfunction

    task automatic note_error(input string msg);
        if (errors < 10)
            $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // hand one item to the block, then predict what it causes
    task automatic issue(input line_cmd_t cmd, input bit typed, input pixel_t want);
        pixel_t pix;
        bit     got;
        if (items_sent % 64 == 0)
        begin
            case ($urandom_range(0, 2))
                0: tx_gap_pct = 0;
                1: tx_gap_pct = 15;
                default: tx_gap_pct = 40;
            endcase
        end
        if (!calm && $urandom_range(0, 99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        action   <= cmd.action;
        x_start  <= cmd.x_start;
        y_start  <= cmd.y_start;
        x_end    <= cmd.x_end;
        y_end    <= cmd.y_end;
        in_valid <= 1'b1;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        items_sent++;
        got = raster_next(cmd, pix);
        if (cmd.action == ACT_LOAD)
        begin
            lines_loaded++;
            useful_items++;
        end
        else if (got)
        begin
            useful_items++;
        end
        if (typed)
            pix_due.push_back(want);
        else if (got)
            pix_due.push_back(pix);
    endtask

    // hold off until every pixel is out and the serial add has finished
    task automatic drain_and_rest();
        in_valid <= 1'b0;
        while (pix_due.size() != 0)
            @(posedge clk);
        repeat (REST_CYCLES) @(posedge clk);
    endtask

    task automatic write_color(input logic [COLOR_W-1:0] c);
        cfg_data  <= c;
        cfg_valid <= 1'b1;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        color_reg = c;
    endtask

    function automatic logic [COORD_W-1:0] jitter_coord(input logic [COORD_W-1:0] c,
                                                        input int reach);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0)
            v = 0;
        if (v > int'(C_MAX))
            v = int'(C_MAX);
        return v[COORD_W-1:0];
    endfunction

    // random line sequences until the useful item count reaches target
    task automatic run_lines(input int target);
        line_cmd_t cmd;
        int        pick;
        int        kind;
        int        reach;
        int        n_steps;
        bit        cut_short;
        while (useful_items < target)
        begin
            pick = $urandom_range(0, 99);
            cmd.x_start = COORD_W'($urandom_range(0, int'(C_MAX)));
            cmd.y_start = COORD_W'($urandom_range(0, int'(C_MAX)));
            cmd.x_end   = COORD_W'($urandom_range(0, int'(C_MAX)));
            cmd.y_end   = COORD_W'($urandom_range(0, int'(C_MAX)));
            if (pick < 8)
            begin
                // noise: stray step, zero-length load, or a load left unused
                cmd.action = (pick < 4) ? ACT_STEP : ACT_LOAD;
                if (pick < 6)
                begin
                    cmd.x_end = cmd.x_start;
                    cmd.y_end = cmd.y_start;
                end
                issue(cmd, 1'b0, '0);
            end
            else
            begin
                kind      = $urandom_range(0, 49);
                cut_short = 1'b0;
                if (kind == 0)
                    reach = 400;
                else if (kind < 5)
                    cut_short = 1'b1;
                else if (kind < 12)
                    reach = 80;
                else
                    reach = 12;
                cmd.action = ACT_LOAD;
                if (!cut_short)
                begin
                    cmd.x_end = jitter_coord(cmd.x_start, reach);
                    cmd.y_end = jitter_coord(cmd.y_start, reach);
                end
                issue(cmd, 1'b0, '0);
                if (cut_short)
                    n_steps = $urandom_range(1, 30);
                else if (pick < 20)
                    n_steps = $urandom_range(0, int'(pix_remaining));
                else
                    n_steps = int'(pix_remaining) + $urandom_range(0, 2);
                cmd.action = ACT_STEP;
                repeat (n_steps) issue(cmd, 1'b0, '0);
            end
        end
    endtask

    // output side: random stall bursts
    always @(posedge clk)
    begin
        rx_tick++;
        if (rx_tick % 64 == 0)
            rx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        if (calm)
        begin
            out_ready <= 1'b1;
        end
        else if (rx_hold != 0)
        begin
            out_ready <= 1'b0;
            rx_hold--;
        end
        else if ($urandom_range(0, 99) < rx_gap_pct)
        begin
            out_ready <= 1'b0;
            rx_hold = $urandom_range(0, 3);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // sample between edges; a pixel seen here is taken at the next rising edge
    always @(negedge clk)
    begin
        pixel_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pix_due.size() == 0)
            begin
                note_error($sformatf("pixel with none pending: x=%0d y=%0d color=%06h last=%0b",
                                     pixel_x, pixel_y, pixel_value, last));
            end
            else
            begin
                w = pix_due.pop_front();
                if (pixel_x !== w.px || pixel_y !== w.py || pixel_value !== w.color ||
                    last !== w.last)
                    note_error($sformatf({"pixel %0d: expected x=%0d y=%0d color=%06h last=%0b,",
                                          " got x=%0d y=%0d color=%06h last=%0b"},
                                         pixels_checked, w.px, w.py, w.color, w.last,
                                         pixel_x, pixel_y, pixel_value, last));
            end
            pixels_checked++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet = quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Watchdog: %0d cycles without a handshake, %0d pixels pending",
                         quiet, pix_due.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        pixel_t    want;
        line_cmd_t cmd;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hand-picked lines at the reset color
        for (int i = 0; i < DIR_N; i++)
        begin
            cmd.action  = dir_rows[i].action;
            cmd.x_start = dir_rows[i].xs;
            cmd.y_start = dir_rows[i].ys;
            cmd.x_end   = dir_rows[i].xe;
            cmd.y_end   = dir_rows[i].ye;
            want.px     = dir_rows[i].wx;
            want.py     = dir_rows[i].wy;
            want.color  = COLOR_RESET;
            want.last   = dir_rows[i].wlast;
            issue(cmd, dir_rows[i].typed, want);
        end

        drain_and_rest();
        write_color('1);
        run_lines(620);

        drain_and_rest();
        write_color('0);
        run_lines(1200);

        // no stalls from here on
        drain_and_rest();
        write_color(COLOR_W'($urandom_range(1, 24'hFFFFFE)));
        calm = 1'b1;
        run_lines(1750);

        drain_and_rest();
        $display("Summary: %0d items sent, %0d lines loaded, %0d pixels compared",
                 items_sent, lines_loaded, pixels_checked);
        $display("Summary: reset color plus full, zero and random colors; %0d mismatches",
                 errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### dda_line_rasterizer_top.f
design/dda_pkg.sv
design/dda_div.sv
design/dda_acc.sv
design/dda_line_rasterizer_top.sv
design/dda_chk.sv
tb/dda_line_rasterizer_top_tb.sv
